>>> hw/rtl/usbs_pkg.sv
// Shared types, constants and the pattern step function for the byte scanner.
`timescale 1ns / 1ps

package usbs_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ALLOW_SEMICOLON    = 3'd0;
    localparam logic [2:0] REG_ALLOW_QUOTES       = 3'd1;
    localparam logic [2:0] REG_ALLOW_DASH_PAIR    = 3'd2;
    localparam logic [2:0] REG_ALLOW_COMMENT_OPEN = 3'd3;
    localparam logic [2:0] REG_CHECK_MARKUP       = 3'd4;
    localparam int unsigned CFG_IDX_W             = 3;

    // Verdict codes
    localparam logic [1:0] VERDICT_SAFE   = 2'd0;
    localparam logic [1:0] VERDICT_CHARS  = 2'd1;
    localparam logic [1:0] VERDICT_SCRIPT = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Markup patterns, lower case, zero padded
    localparam int N_PAT   = 4;
    localparam int PAT_MAX = 11;
    localparam int PROG_W  = 4;

    localparam logic [7:0] PAT_BYTES [N_PAT][PAT_MAX] = '{
        '{"<", "s", "c", "r", "i", "p", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"j", "a", "v", "a", "s", "c", "r", "i", "p", "t", ":"},
        '{"o", "n", "e", "r", "r", "o", "r", "=", 8'h00, 8'h00, 8'h00},
        '{"o", "n", "l", "o", "a", "d", "=", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int PAT_LEN [N_PAT] = '{7, 11, 8, 7};

    // One request moving along the cell row
    typedef struct packed {
        logic       valid;
        logic [7:0] text;
        logic       present;
        logic       last;
        logic       char_flag;
        logic       markup_flag;
    } t_lane;

    // Next matched-prefix length for a byte; the top bit flags a full match.
    // A candidate length k fits when the byte closes the prefix and the
    // tail of the current prefix equals the head of the pattern.
    function automatic logic [PROG_W:0] kmp_step(input int pid,
                                                 input logic [PROG_W-1:0] prog,
                                                 input logic [7:0] c);
        int   len;
        int   p;
        int   best;
        logic ok;
        logic hit;
        len  = PAT_LEN[pid];
        p    = int'(prog);
        best = 0;
        hit  = 1'b0;
        if (p >= len) begin
            p = 0;
        end
        for (int k = 1; k <= PAT_MAX; k++) begin
            if (k <= len && k <= p + 1) begin
                ok = (c == PAT_BYTES[pid][k-1]);
                for (int i = 0; i < PAT_MAX - 1; i++) begin
                    if (i <= k - 2) begin
                        ok = ok & (PAT_BYTES[pid][p-k+1+i] == PAT_BYTES[pid][i]);
                    end
                end
                if (ok) begin
                    best = k;
                end
            end
        end
        if (best == len) begin
            hit  = 1'b1;
            best = 0;
        end
        return {hit, PROG_W'(best)};
    endfunction

endpackage

>>> hw/rtl/usbs_char_cell.sv
// First cell of the row: dangerous character and pair checks, lower-casing.
`timescale 1ns / 1ps

module usbs_char_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_allow_semicolon,
    input  logic            i_allow_quotes,
    input  logic            i_allow_dash_pair,
    input  logic            i_allow_comment_open,
    input  usbs_pkg::t_lane i_lane,
    output usbs_pkg::t_lane o_lane
);
    import usbs_pkg::*;

    logic [7:0] r_prev;
    logic [7:0] n_prev;
    logic       r_hit;
    logic       n_hit;
    t_lane      r_lane;
    t_lane      n_lane;
    logic       hit_now;
    logic [7:0] lc;

    // Per-byte checks against the allow registers
    always_comb begin
        hit_now = 1'b0;
        if (!i_allow_semicolon && i_lane.text == CH_SEMICOLON) begin
            hit_now = 1'b1;
        end
        if (!i_allow_quotes && (i_lane.text == CH_SQUOTE || i_lane.text == CH_DQUOTE)) begin
            hit_now = 1'b1;
        end
        if (!i_allow_dash_pair && r_prev == CH_DASH && i_lane.text == CH_DASH) begin
            hit_now = 1'b1;
        end
        if (!i_allow_comment_open && r_prev == CH_SLASH && i_lane.text == CH_STAR) begin
            hit_now = 1'b1;
        end
        lc = (i_lane.text inside {[CH_UPPER_A:CH_UPPER_Z]}) ?
             i_lane.text + CASE_OFFSET : i_lane.text;
    end

    // State update and hand-off
    always_comb begin
        n_prev = r_prev;
        n_hit  = r_hit;
        n_lane = i_lane;
        n_lane.text      = lc;
        n_lane.char_flag = 1'b0;
        if (i_lane.valid && i_lane.present) begin
            n_hit  = r_hit | hit_now;
            n_prev = i_lane.text;
        end
        if (i_lane.valid && i_lane.last) begin
            n_lane.char_flag = n_hit;
            n_hit  = 1'b0;
            n_prev = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 8'h00;
            r_hit        <= 1'b0;
            r_lane.valid <= 1'b0;
        end else if (i_adv) begin
            r_prev <= n_prev;
            r_hit  <= n_hit;
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> hw/rtl/usbs_match_cell.sv
// Pattern cell: tracks the matched prefix of one markup pattern.
`timescale 1ns / 1ps

module usbs_match_cell #(
    parameter int PAT_ID = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  usbs_pkg::t_lane i_lane,
    output usbs_pkg::t_lane o_lane
);
    import usbs_pkg::*;

    logic [PROG_W-1:0] r_prog;
    logic [PROG_W-1:0] n_prog;
    logic              r_hit;
    logic              n_hit;
    t_lane             r_lane;
    t_lane             n_lane;
    logic [PROG_W:0]   step;

    assign step = kmp_step(PAT_ID, r_prog, i_lane.text);

    // Advance the match, fold the sticky hit into the request on the last byte
    always_comb begin
        n_prog = r_prog;
        n_hit  = r_hit;
        n_lane = i_lane;
        if (i_lane.valid && i_lane.present) begin
            n_prog = step[PROG_W-1:0];
            n_hit  = r_hit | step[PROG_W];
        end
        if (i_lane.valid && i_lane.last) begin
            n_lane.markup_flag = i_lane.markup_flag | n_hit;
            n_hit  = 1'b0;
            n_prog = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog       <= '0;
            r_hit        <= 1'b0;
            r_lane.valid <= 1'b0;
        end else if (i_adv) begin
            r_prog <= n_prog;
            r_hit  <= n_hit;
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> hw/rtl/unsafe_string_byte_scanner_top.sv
// Top level of the unsafe string byte scanner: cell row, config and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte of a string per
//   request, with i_byte_present and i_end_of_string. An empty string is one
//   request with i_byte_present low and i_end_of_string high.
//   Output channel (o_out_valid / i_out_stall) carries one 2-bit verdict per
//   string: 0 safe, 1 dangerous characters, 2 script content.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes register
//   i_cfg_index with i_cfg_data; write only while no string is in flight.
//   Throughput: one byte per cycle while the row is not held (see below).
//   The row is one character cell and four pattern cells plus the result
//   register, which each request passes in order before o_out_valid rises.
//   When the receiver stalls with a verdict held, the whole row holds and
//   o_in_stall rises in the same cycle; otherwise requests flow every cycle.
//   Reset clears all match state and sets the registers to their defaults
//   (all allow bits 0, markup check on).
`timescale 1ns / 1ps

module unsafe_string_byte_scanner_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_byte_present,
    input  logic                           i_end_of_string,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_verdict,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [usbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);
    import usbs_pkg::*;

    logic       r_allow_semicolon;
    logic       r_allow_quotes;
    logic       r_allow_dash_pair;
    logic       r_allow_comment_open;
    logic       r_check_markup;
    logic       r_out_valid;
    logic [1:0] r_verdict;
    logic [1:0] n_verdict;
    logic       adv;
    t_lane      in_lane;
    t_lane      lanes [N_PAT+1];

    // Config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_semicolon    <= 1'b0;
            r_allow_quotes       <= 1'b0;
            r_allow_dash_pair    <= 1'b0;
            r_allow_comment_open <= 1'b0;
            r_check_markup       <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ALLOW_SEMICOLON:    r_allow_semicolon    <= i_cfg_data;
                REG_ALLOW_QUOTES:       r_allow_quotes       <= i_cfg_data;
                REG_ALLOW_DASH_PAIR:    r_allow_dash_pair    <= i_cfg_data;
                REG_ALLOW_COMMENT_OPEN: r_allow_comment_open <= i_cfg_data;
                REG_CHECK_MARKUP:       r_check_markup       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row advances unless a held verdict is stalled
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    always_comb begin
        in_lane.valid       = i_in_valid;
        in_lane.text        = i_text_byte;
        in_lane.present     = i_byte_present;
        in_lane.last        = i_end_of_string;
        in_lane.char_flag   = 1'b0;
        in_lane.markup_flag = 1'b0;
    end

    usbs_char_cell u_char (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adv                (adv),
        .i_allow_semicolon    (r_allow_semicolon),
        .i_allow_quotes       (r_allow_quotes),
        .i_allow_dash_pair    (r_allow_dash_pair),
        .i_allow_comment_open (r_allow_comment_open),
        .i_lane               (in_lane),
        .o_lane               (lanes[0])
    );

    // One cell per markup pattern
    for (genvar g = 0; g < N_PAT; g++) begin : g_match
        usbs_match_cell #(
            .PAT_ID (g)
        ) u_match (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_lane  (lanes[g]),
            .o_lane  (lanes[g+1])
        );
    end

    // Verdict priority: characters over markup
    always_comb begin
        if (lanes[N_PAT].char_flag) begin
            n_verdict = VERDICT_CHARS;
        end else if (r_check_markup && lanes[N_PAT].markup_flag) begin
            n_verdict = VERDICT_SCRIPT;
        end else begin
            n_verdict = VERDICT_SAFE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= lanes[N_PAT].valid && lanes[N_PAT].last;
            r_verdict   <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the unsafe string byte scanner top level.
`timescale 1ns / 1ps

module tb_top;
    import usbs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 285;
    localparam int N_DIR         = 10;
    localparam int N_MARKUP      = 4;

    // Markup patterns, lower case, first character in the top byte
    localparam logic [8*7-1:0]  TAG_PAT    = "<script";
    localparam logic [8*11-1:0] SCHEME_PAT = "javascript:";
    localparam logic [8*8-1:0]  ERR_PAT    = "onerror=";
    localparam logic [8*7-1:0]  LOAD_PAT   = "onload=";
    localparam int MK_LEN [N_MARKUP] = '{7, 11, 8, 7};

    localparam logic [2:0] REG_ORDER [5] = '{REG_ALLOW_SEMICOLON, REG_ALLOW_QUOTES,
                                             REG_ALLOW_DASH_PAIR, REG_ALLOW_COMMENT_OPEN,
                                             REG_CHECK_MARKUP};

    typedef struct {
        logic [8*12-1:0] text;
        int              n;
        bit              lead_blank;
        bit              known;
        logic [1:0]      verdict;
    } t_dir_row;

    // DUT connections
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_text_byte     = '0;
    logic                 i_byte_present  = 1'b0;
    logic                 i_end_of_string = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [1:0]           o_verdict;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic                 i_cfg_data      = 1'b0;

    // Predictor configuration, reset values
    bit cf_semi   = 1'b0;
    bit cf_quote  = 1'b0;
    bit cf_dash   = 1'b0;
    bit cf_cmt    = 1'b0;
    bit cf_markup = 1'b1;

    // Predictor string state
    bit         seen_char   = 1'b0;
    bit         seen_markup = 1'b0;
    logic [7:0] prev_b      = '0;
    int         mk_prog [N_MARKUP] = '{0, 0, 0, 0};

    logic [1:0] verdict_q [$];          // expected verdicts, oldest first
    logic [2:0] typed_verdict_q [$];    // {typed, verdict} per string end driven
    logic [7:0] str_q [$];              // bytes of the string being built

    int  sender_gap_pct = 0;
    int  sink_stall_pct = 0;
    int  items_sent     = 0;
    int  mismatches     = 0;
    int  cycle_cnt      = 0;

    bit         mon_fire;
    logic [1:0] mon_v;
    logic [2:0] mon_tag;
    logic [1:0] chk_exp;

    t_dir_row dir_tab [N_DIR];

    unsafe_string_byte_scanner_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_verdict       (o_verdict),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Character i of markup pattern id
    function automatic logic [7:0] mk_char(input int id, input int i);
        case (id)
            0:       return TAG_PAT[8*(6-i) +: 8];
            1:       return SCHEME_PAT[8*(10-i) +: 8];
            2:       return ERR_PAT[8*(7-i) +: 8];
            default: return LOAD_PAT[8*(6-i) +: 8];
        endcase
    endfunction

    // Longest pattern prefix that ends the matched text plus byte c
    function automatic int mk_advance(input int id, input int p, input logic [7:0] c,
                                      output bit full);
        int         len;
        int         n;
        int         k;
        int         j;
        bit         ok;
        logic [7:0] b;
        full = 1'b0;
        len  = MK_LEN[id];
        if (p >= len || p < 0) begin
            p = 0;
        end
        n = p + 1;
        for (k = n; k > 0; k--) begin
            ok = 1'b1;
            for (j = 0; j < k; j++) begin
                b = (n - k + j < p) ? mk_char(id, n - k + j) : c;
                if (b != mk_char(id, j)) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                if (k == len) begin
                    full = 1'b1;
                    return 0;
                end
                return k;
            end
        end
        return 0;
    endfunction

    // Scanner model: one request in, possibly one verdict out
    function automatic void scan_item(input logic [7:0] c, input logic pres, input logic last,
                                      output bit fire, output logic [1:0] v);
        logic [7:0] lc;
        bit         full;
        int         id;
        fire = 1'b0;
        v    = VERDICT_SAFE;
        if (pres) begin
            lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
            if (!cf_semi && c == CH_SEMICOLON) seen_char = 1'b1;
            if (!cf_quote && (c == CH_SQUOTE || c == CH_DQUOTE)) seen_char = 1'b1;
            if (!cf_dash && prev_b == CH_DASH && c == CH_DASH) seen_char = 1'b1;
            if (!cf_cmt && prev_b == CH_SLASH && c == CH_STAR) seen_char = 1'b1;
            for (id = 0; id < N_MARKUP; id++) begin
                mk_prog[id] = mk_advance(id, mk_prog[id], lc, full);
                if (full) seen_markup = 1'b1;
            end
            prev_b = c;
        end
        if (last) begin
            fire = 1'b1;
            if (seen_char) v = VERDICT_CHARS;
            else if (cf_markup && seen_markup) v = VERDICT_SCRIPT;
            seen_char   = 1'b0;
            seen_markup = 1'b0;
            prev_b      = '0;
            for (id = 0; id < N_MARKUP; id++) mk_prog[id] = 0;
        end
    endfunction

    // Append one byte to the string being built
    function automatic void str_add(input logic [7:0] b);
        str_q.insert(str_q.size(), b);
    endfunction

    // Input monitor: predict at each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            scan_item(i_text_byte, i_byte_present, i_end_of_string, mon_fire, mon_v);
            if (mon_fire) begin
                mon_tag = typed_verdict_q.pop_front();
                verdict_q.insert(verdict_q.size(), mon_tag[2] ? mon_tag[1:0] : mon_v);
            end
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict mismatch, expected none, actual %0d", $time, o_verdict);
                mismatches++;
            end else begin
                chk_exp = verdict_q.pop_front();
                if (chk_exp !== o_verdict) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, chk_exp, o_verdict);
                    mismatches++;
                end
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive one request and hold it until taken
    task automatic push_item(input logic [7:0] b, input logic pres, input logic last,
                             input bit known, input logic [1:0] v);
        while ($urandom_range(99, 0) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (last) typed_verdict_q.insert(typed_verdict_q.size(), {known, v});
        i_in_valid      <= 1'b1;
        i_text_byte     <= b;
        i_byte_present  <= pres;
        i_end_of_string <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (pres || last) items_sent++;
    endtask

    // Send str_q as one string; an empty queue becomes the empty-string request
    task automatic send_string(input bit known, input logic [1:0] v, input bit lead_blank,
                               input bit blank_end, input int noise_pct);
        int i;
        if (lead_blank)
            push_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0, VERDICT_SAFE);
        for (i = 0; i < str_q.size(); i++) begin
            if ($urandom_range(99, 0) < noise_pct)
                push_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0, VERDICT_SAFE);
            push_item(str_q[i], 1'b1, (i == str_q.size() - 1) && !blank_end, known, v);
        end
        if (blank_end || str_q.size() == 0)
            push_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, known, v);
    endtask

    // Random string made of markup fragments, risky characters and filler
    task automatic build_string();
        int         target;
        int         r;
        int         id;
        int         n;
        int         i;
        logic [7:0] ch;
        str_q.delete();
        target = ($urandom_range(99, 0) < 4) ? 0 : $urandom_range(10, 1);
        while (str_q.size() < target) begin
            r = $urandom_range(99, 0);
            if (r < 35) begin
                id = $urandom_range(N_MARKUP - 1, 0);
                n  = ($urandom_range(2, 0) == 0) ? $urandom_range(MK_LEN[id] - 1, 1)
                                                 : MK_LEN[id];
                for (i = 0; i < n; i++) begin
                    ch = mk_char(id, i);
                    if (ch >= "a" && ch <= "z" && $urandom_range(1, 0)) ch = ch - CASE_OFFSET;
                    str_add(ch);
                end
            end else if (r < 47) begin
                case ($urandom_range(5, 0))
                    0: str_add(CH_SEMICOLON);
                    1: str_add(CH_SQUOTE);
                    2: str_add(CH_DQUOTE);
                    3: begin
                        str_add(CH_DASH);
                        str_add(CH_DASH);
                    end
                    4: begin
                        str_add(CH_SLASH);
                        str_add(CH_STAR);
                    end
                    default: begin
                        r = $urandom_range(2, 0);
                        str_add(r == 0 ? CH_DASH : (r == 1 ? CH_SLASH : CH_STAR));
                    end
                endcase
            end else if (r < 75) begin
                str_add(8'($urandom_range(255, 0)));
            end else begin
                str_add(8'($urandom_range(126, 32)));
            end
        end
    endtask

    // Let all verdicts come back, then let the row empty out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all five registers; bit r of cfg goes to REG_ORDER[r]
    task automatic load_config(input logic [4:0] cfg);
        int r;
        for (r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[r];
            i_cfg_data  <= cfg[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (REG_ORDER[r])
                REG_ALLOW_SEMICOLON:    cf_semi   = cfg[r];
                REG_ALLOW_QUOTES:       cf_quote  = cfg[r];
                REG_ALLOW_DASH_PAIR:    cf_dash   = cfg[r];
                REG_ALLOW_COMMENT_OPEN: cf_cmt    = cfg[r];
                REG_CHECK_MARKUP:       cf_markup = cfg[r];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        int         ph;
        int         row;
        int         i;
        int         goal;
        logic [4:0] cfg;

        dir_tab = '{
            '{0,                3, 1'b0, 1'b1, VERDICT_SAFE},    // empty string
            '{";",              1, 1'b0, 1'b1, VERDICT_CHARS},
            '{"'",              1, 1'b0, 1'b1, VERDICT_CHARS},
            '{"\"",             1, 1'b0, 1'b1, VERDICT_CHARS},
            '{"a--",            3, 1'b0, 1'b1, VERDICT_CHARS},
            '{"-",              1, 1'b0, 1'b1, VERDICT_SAFE},    // no pair across strings
            '{"/*",             2, 1'b0, 1'b1, VERDICT_CHARS},
            '{{8'h00, 8'hFF},   2, 1'b1, 1'b1, VERDICT_SAFE},    // ignored blank first
            '{"<SCRIPT",        7, 1'b0, 1'b1, VERDICT_SCRIPT},
            '{"ononload=",      9, 1'b0, 1'b0, VERDICT_SAFE}     // overlap, predicted
        };
        dir_tab[0].n = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings under reset configuration
        sender_gap_pct = 15;
        sink_stall_pct = 67;
        for (row = 0; row < N_DIR; row++) begin
            str_q.delete();
            for (i = 0; i < dir_tab[row].n; i++)
                str_add(dir_tab[row].text[8*(dir_tab[row].n-1-i) +: 8]);
            send_string(dir_tab[row].known, dir_tab[row].verdict, dir_tab[row].lead_blank,
                        1'b0, 0);
        end

        // Random phases, each with its own register setting; each pair of phases shares an idle mix
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph / 2)
                0: begin
                    sender_gap_pct = 15;
                    sink_stall_pct = 67;
                end
                1: begin
                    sender_gap_pct = 67;
                    sink_stall_pct = 15;
                end
                default: begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            case (ph)
                0:       cfg = 5'b10000;
                1:       cfg = 5'b11111;
                2:       cfg = 5'b00000;
                default: cfg = 5'($urandom_range(31, 0));
            endcase
            load_config(cfg);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                build_string();
                send_string(1'b0, VERDICT_SAFE, 1'b0,
                            (str_q.size() != 0) && ($urandom_range(9, 0) == 0), 3);
            end
        end

        drain();
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
